// File: rtl/ihc_pkg.sv
package ihc_pkg;

	localparam int unsigned LEVEL_W = 12;
	localparam int unsigned DELAY_W = 10;
	localparam int unsigned INDEX_W = 3;

	localparam logic [DELAY_W-1:0] COUNT_MAX = {DELAY_W{1'b1}};

	// Button detector phases.
	localparam logic [1:0] PH_WAIT_PRESS   = 2'd0;
	localparam logic [1:0] PH_WAIT_RELEASE = 2'd1;
	localparam logic [1:0] PH_FIRE         = 2'd2;
	localparam logic [1:0] PH_UNUSED       = 2'd3;

	// Configuration register indexes.
	localparam logic [INDEX_W-1:0] REG_KNOB_ON   = 3'd0;
	localparam logic [INDEX_W-1:0] REG_KNOB_OFF  = 3'd1;
	localparam logic [INDEX_W-1:0] REG_DAYLIGHT  = 3'd2;
	localparam logic [INDEX_W-1:0] REG_DUSK      = 3'd3;
	localparam logic [INDEX_W-1:0] REG_OFF_DELAY = 3'd4;
	localparam logic [INDEX_W-1:0] REG_ON_DELAY  = 3'd5;

	// Reset values: 0.8, 0.2, 0.8 and 0.6 of full scale; 2000 ms and 1000 ms in 20 ms ticks.
	localparam logic [LEVEL_W-1:0] RST_KNOB_ON   = 12'd3276;
	localparam logic [LEVEL_W-1:0] RST_KNOB_OFF  = 12'd819;
	localparam logic [LEVEL_W-1:0] RST_DAYLIGHT  = 12'd3276;
	localparam logic [LEVEL_W-1:0] RST_DUSK      = 12'd2457;
	localparam logic [DELAY_W-1:0] RST_OFF_DELAY = 10'd100;
	localparam logic [DELAY_W-1:0] RST_ON_DELAY  = 10'd50;

	typedef struct packed {
		logic               ignition_level;
		logic               seat_occupied;
		logic [LEVEL_W-1:0] knob_sample;
		logic [LEVEL_W-1:0] light_sample;
	} tick_beat_t;

	typedef struct packed {
		logic engine_running;
		logic lamps_lit;
	} result_beat_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] knob_on_level;
		logic [LEVEL_W-1:0] knob_off_level;
		logic [LEVEL_W-1:0] bright_level;
		logic [LEVEL_W-1:0] dark_level;
		logic [DELAY_W-1:0] off_delay_ticks;
		logic [DELAY_W-1:0] on_delay_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         button_phase;
		logic               engine_on;
		logic               lamps_on;
		logic [DELAY_W-1:0] elapsed_ticks;
	} ctrl_state_t;

endpackage

// File: rtl/ihc_cfg_regs.sv
module ihc_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ihc_pkg::INDEX_W-1:0]        cfg_index,
	input  logic [ihc_pkg::LEVEL_W-1:0]        cfg_data,
	output ihc_pkg::cfg_t                      cfg
);

	ihc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.knob_on_level   <= ihc_pkg::RST_KNOB_ON;
			cfg_q.knob_off_level  <= ihc_pkg::RST_KNOB_OFF;
			cfg_q.bright_level    <= ihc_pkg::RST_DAYLIGHT;
			cfg_q.dark_level      <= ihc_pkg::RST_DUSK;
			cfg_q.off_delay_ticks <= ihc_pkg::RST_OFF_DELAY;
			cfg_q.on_delay_ticks  <= ihc_pkg::RST_ON_DELAY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ihc_pkg::REG_KNOB_ON:   cfg_q.knob_on_level   <= cfg_data;
				ihc_pkg::REG_KNOB_OFF:  cfg_q.knob_off_level  <= cfg_data;
				ihc_pkg::REG_DAYLIGHT:  cfg_q.bright_level    <= cfg_data;
				ihc_pkg::REG_DUSK:      cfg_q.dark_level      <= cfg_data;
				ihc_pkg::REG_OFF_DELAY: cfg_q.off_delay_ticks <= cfg_data[ihc_pkg::DELAY_W-1:0];
				ihc_pkg::REG_ON_DELAY:  cfg_q.on_delay_ticks  <= cfg_data[ihc_pkg::DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/ihc_step.sv
module ihc_step (
	input  ihc_pkg::ctrl_state_t cur,
	input  ihc_pkg::tick_beat_t  tick,
	input  ihc_pkg::cfg_t        cfg,
	output ihc_pkg::ctrl_state_t nxt
);

	logic                        fire;
	logic [1:0]                  phase_nxt;
	logic                        engine_nxt;
	logic [ihc_pkg::DELAY_W-1:0] count_inc;
	logic                        off_due;
	logic                        on_due;

	// Press/release detector: fires one tick after the release is seen.
	always_comb begin
		fire      = 1'b0;
		phase_nxt = cur.button_phase;
		unique case (cur.button_phase)
			ihc_pkg::PH_WAIT_PRESS: begin
				if (tick.ignition_level) phase_nxt = ihc_pkg::PH_WAIT_RELEASE;
			end
			ihc_pkg::PH_WAIT_RELEASE: begin
				if (!tick.ignition_level) phase_nxt = ihc_pkg::PH_FIRE;
			end
			ihc_pkg::PH_FIRE: begin
				fire      = 1'b1;
				phase_nxt = ihc_pkg::PH_WAIT_PRESS;
			end
			default: phase_nxt = ihc_pkg::PH_WAIT_PRESS;
		endcase
	end

	always_comb begin
		engine_nxt = cur.engine_on;
		if (fire) engine_nxt = cur.engine_on ? 1'b0 : tick.seat_occupied;
	end

	// The counter saturates before it is compared with the delay.
	assign count_inc = (cur.elapsed_ticks == ihc_pkg::COUNT_MAX) ? cur.elapsed_ticks
	                   : cur.elapsed_ticks + 1'b1;
	assign off_due   = count_inc >= cfg.off_delay_ticks;
	assign on_due    = count_inc >= cfg.on_delay_ticks;

	always_comb begin
		nxt.button_phase  = phase_nxt;
		nxt.engine_on     = engine_nxt;
		nxt.lamps_on      = cur.lamps_on;
		nxt.elapsed_ticks = cur.elapsed_ticks;
		if (!engine_nxt) begin
			nxt.lamps_on = 1'b0;
		end else if (tick.knob_sample >= cfg.knob_on_level) begin
			nxt.lamps_on = 1'b1;
		end else if (tick.knob_sample <= cfg.knob_off_level) begin
			nxt.lamps_on = 1'b0;
		end else if (tick.light_sample >= cfg.bright_level) begin
			if (off_due) begin
				nxt.lamps_on      = 1'b0;
				nxt.elapsed_ticks = '0;
			end else begin
				nxt.elapsed_ticks = count_inc;
			end
		end else if (tick.light_sample <= cfg.dark_level) begin
			if (on_due) begin
				nxt.lamps_on      = 1'b1;
				nxt.elapsed_ticks = '0;
			end else begin
				nxt.elapsed_ticks = count_inc;
			end
		end else begin
			nxt.elapsed_ticks = '0;
		end
	end

endmodule

// File: rtl/ignition_and_auto_headlamp_controller_core.sv
// Channel   Direction  Handshake                  Payload
// tick      in         tick_valid / tick_ready    ihc_pkg::tick_beat_t, one 20 ms tick
// result    out        result_valid/result_ready  ihc_pkg::result_beat_t, one per tick
// cfg       in         cfg_we (no wait)           cfg_index, cfg_data
//
// Every tick beat gives exactly one result beat. A taken tick passes from the input register
// to the result register, which offers it with result_valid, and the block takes a new tick
// beat in every cycle while results flow.
// The input register and the result register both hold a beat, so a stalled result
// still lets one more tick be taken; only then does tick_ready drop.
// Reset (arst_n low) clears the detector, engine, lamps and counter and loads the
// register defaults; no clearing pass is needed.
module ignition_and_auto_headlamp_controller_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        tick_valid,
	output logic                        tick_ready,
	input  ihc_pkg::tick_beat_t         tick,
	output logic                        result_valid,
	input  logic                        result_ready,
	output ihc_pkg::result_beat_t       result,
	input  logic                        cfg_we,
	input  logic [ihc_pkg::INDEX_W-1:0] cfg_index,
	input  logic [ihc_pkg::LEVEL_W-1:0] cfg_data
);

	ihc_pkg::cfg_t         cfg;
	ihc_pkg::tick_beat_t   tick_s1;
	logic                  tick_valid_s1;
	ihc_pkg::ctrl_state_t  state_q;
	ihc_pkg::ctrl_state_t  state_nxt;
	ihc_pkg::result_beat_t result_q;
	logic                  result_valid_q;
	logic                  advance;

	ihc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The buffered tick is processed when the result register is empty or being emptied.
	assign advance    = tick_valid_s1 && (!result_valid_q || result_ready);
	assign tick_ready = !tick_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid_s1 <= 1'b0;
		end else if (tick_ready) begin
			tick_valid_s1 <= tick_valid;
		end
	end

	// Payload register, loaded only when a beat is taken.
	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready) begin
			tick_s1 <= tick;
		end
	end

	ihc_step u_step (
		.cur  (state_q),
		.tick (tick_s1),
		.cfg  (cfg),
		.nxt  (state_nxt)
	);

	// Controller state moves on exactly once per processed tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.button_phase  <= ihc_pkg::PH_WAIT_PRESS;
			state_q.engine_on     <= 1'b0;
			state_q.lamps_on      <= 1'b0;
			state_q.elapsed_ticks <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.engine_running <= state_nxt.engine_on;
			result_q.lamps_lit      <= state_nxt.lamps_on;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: rtl/ihc_checker.sv
module ihc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        tick_ready,
	input logic                        result_valid,
	input logic                        result_ready,
	input ihc_pkg::result_beat_t       result
);

	// A stalled result beat holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// Lamps are never lit with the engine off.
	a_lamps_need_engine: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.engine_running || !result.lamps_lit))
		else $error("lamps lit with engine off");

	// Input back-pressure only arises behind a stalled result.
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_ready |-> (result_valid && !result_ready))
		else $error("tick_ready low without an output stall");

	// An empty result register means the next tick is always taken.
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> tick_ready)
		else $error("tick refused while result register empty");

endmodule

bind ignition_and_auto_headlamp_controller_core ihc_checker u_ihc_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

	// Timing of the run. A taken tick passes the input register and then the result register, so
	// the spare SETTLE_CYCLES are enough to be sure that the block has gone quiet.
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES = 80;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASE_ITEMS = 36;
	localparam int CEILING_ITEMS = 520;

	// Indexes beyond the register file; the block must ignore writes to them.
	localparam logic [ihc_pkg::INDEX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [ihc_pkg::INDEX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum int {LIGHT_DAY, LIGHT_DUSK, LIGHT_MID, LIGHT_ANY} light_band_e;
	typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tick_valid = 1'b0;
	logic tick_ready;
	ihc_pkg::tick_beat_t tick = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	ihc_pkg::result_beat_t result;
	logic cfg_we = 1'b0;
	logic [ihc_pkg::INDEX_W-1:0] cfg_index = '0;
	logic [ihc_pkg::LEVEL_W-1:0] cfg_data = '0;

	ignition_and_auto_headlamp_controller_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_ready   (tick_ready),
		.tick         (tick),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// Our own copy of the controller: configuration and state as they stand after the
	// last tick that the block has taken.
	ihc_pkg::cfg_t model_cfg;
	logic [1:0] btn_phase;
	logic engine_on;
	logic lamps_on;
	logic [ihc_pkg::DELAY_W-1:0] dwell_ticks;

	// Lamp and engine states that the block still owes us, oldest first.
	ihc_pkg::result_beat_t pending_results[$];
	int mismatches = 0;

	// Sender pacing and the receiver's long hold-off request.
	int burst_left = 0;
	bit pacing_on = 1'b1;
	int hold_asks = 0;

	function automatic void reset_model();
		model_cfg.knob_on_level = ihc_pkg::RST_KNOB_ON;
		model_cfg.knob_off_level = ihc_pkg::RST_KNOB_OFF;
		model_cfg.bright_level = ihc_pkg::RST_DAYLIGHT;
		model_cfg.dark_level = ihc_pkg::RST_DUSK;
		model_cfg.off_delay_ticks = ihc_pkg::RST_OFF_DELAY;
		model_cfg.on_delay_ticks = ihc_pkg::RST_ON_DELAY;
		btn_phase = ihc_pkg::PH_WAIT_PRESS;
		engine_on = 1'b0;
		lamps_on = 1'b0;
		dwell_ticks = '0;
	endfunction

	// Daylight and dusk share one counter. It stops at its ceiling, and once it reaches
	// the delay the lamps take the target state and the count starts again from zero.
	function automatic void count_toward(input logic [ihc_pkg::DELAY_W-1:0] delay,
			input logic target);
		if (dwell_ticks != ihc_pkg::COUNT_MAX) begin
			dwell_ticks = dwell_ticks + 1'b1;
		end
		if (dwell_ticks >= delay) begin
			lamps_on = target;
			dwell_ticks = '0;
		end
	endfunction

	// Advances the controller by one tick and gives the states that the block must report.
	function automatic ihc_pkg::result_beat_t step_controller(input ihc_pkg::tick_beat_t beat);
		logic fire;
		ihc_pkg::result_beat_t r;
		fire = 1'b0;
		case (btn_phase)
			ihc_pkg::PH_WAIT_PRESS: begin
				if (beat.ignition_level) btn_phase = ihc_pkg::PH_WAIT_RELEASE;
			end
			ihc_pkg::PH_WAIT_RELEASE: begin
				if (!beat.ignition_level) btn_phase = ihc_pkg::PH_FIRE;
			end
			ihc_pkg::PH_FIRE: begin
				btn_phase = ihc_pkg::PH_WAIT_PRESS;
				fire = 1'b1;
			end
			default: begin
				btn_phase = ihc_pkg::PH_WAIT_PRESS;
			end
		endcase
		// A firing always stops a running engine, but starts one only with the seat taken.
		if (fire) begin
			if (engine_on) engine_on = 1'b0;
			else if (beat.seat_occupied) engine_on = 1'b1;
		end
		if (!engine_on) begin
			lamps_on = 1'b0;
		end else if (beat.knob_sample >= model_cfg.knob_on_level) begin
			lamps_on = 1'b1;
		end else if (beat.knob_sample <= model_cfg.knob_off_level) begin
			lamps_on = 1'b0;
		end else if (beat.light_sample >= model_cfg.bright_level) begin
			count_toward(model_cfg.off_delay_ticks, 1'b0);
		end else if (beat.light_sample <= model_cfg.dark_level) begin
			count_toward(model_cfg.on_delay_ticks, 1'b1);
		end else begin
			dwell_ticks = '0;
		end
		r.engine_running = engine_on;
		r.lamps_lit = lamps_on;
		return r;
	endfunction

	function automatic ihc_pkg::tick_beat_t make_tick(input logic ign, input logic seat,
			input logic [ihc_pkg::LEVEL_W-1:0] knob, input logic [ihc_pkg::LEVEL_W-1:0] light);
		ihc_pkg::tick_beat_t t;
		t.ignition_level = ign;
		t.seat_occupied = seat;
		t.knob_sample = knob;
		t.light_sample = light;
		return t;
	endfunction

	// Knob samples lean towards the auto band, where most of the behaviour lives, with
	// the two thresholds and the ends of the scale mixed in.
	function automatic logic [ihc_pkg::LEVEL_W-1:0] pick_knob();
		int r;
		int lo;
		int hi;
		r = $urandom_range(0, 9);
		lo = model_cfg.knob_off_level + 1;
		hi = model_cfg.knob_on_level - 1;
		if (r == 0) return 12'($urandom_range(0, 4095));
		if (r == 1) return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
		if (r == 2) return $urandom_range(0, 1) ? model_cfg.knob_on_level : model_cfg.knob_off_level;
		if (lo <= hi) return 12'($urandom_range(hi, lo));
		return 12'($urandom_range(0, 4095));
	endfunction

	function automatic logic [ihc_pkg::LEVEL_W-1:0] pick_light(input light_band_e band);
		int lo;
		int hi;
		case (band)
			LIGHT_DAY: begin
				lo = model_cfg.bright_level;
				hi = 4095;
			end
			LIGHT_DUSK: begin
				lo = 0;
				hi = model_cfg.dark_level;
			end
			LIGHT_MID: begin
				lo = model_cfg.dark_level + 1;
				hi = model_cfg.bright_level - 1;
			end
			default: begin
				lo = 0;
				hi = 4095;
			end
		endcase
		// An empty band (levels that touch or overlap) falls back to the full scale.
		if (lo > hi) begin
			lo = 0;
			hi = 4095;
		end
		if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 12'(hi) : 12'(lo);
		return 12'($urandom_range(hi, lo));
	endfunction

	// Offers one tick beat and holds it until taken. The prediction is made at the edge
	// of acceptance. Between bursts the sender drops valid for a random gap.
	task automatic send_tick(input ihc_pkg::tick_beat_t beat);
		int gap;
		tick_valid <= 1'b1;
		tick <= beat;
		@(posedge clk);
		while (!tick_ready) @(posedge clk);
		pending_results.push_back(step_controller(beat));
		if (pacing_on) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				                                         : $urandom_range(0, 8);
				gap = $urandom_range(1, 6);
				tick_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Press, release, and the tick on which the detector fires.
	task automatic press_and_release(input logic seat, input logic [ihc_pkg::LEVEL_W-1:0] knob,
			input logic [ihc_pkg::LEVEL_W-1:0] light);
		send_tick(make_tick(1'b1, seat, knob, light));
		send_tick(make_tick(1'b0, seat, knob, light));
		send_tick(make_tick(1'b0, seat, knob, light));
	endtask

	// Stops offering ticks and waits until the block has answered every one of them.
	task automatic wait_idle();
		tick_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ihc_pkg::INDEX_W-1:0] idx,
			input logic [ihc_pkg::LEVEL_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			ihc_pkg::REG_KNOB_ON:   model_cfg.knob_on_level = data;
			ihc_pkg::REG_KNOB_OFF:  model_cfg.knob_off_level = data;
			ihc_pkg::REG_DAYLIGHT:  model_cfg.bright_level = data;
			ihc_pkg::REG_DUSK:      model_cfg.dark_level = data;
			ihc_pkg::REG_OFF_DELAY: model_cfg.off_delay_ticks = data[ihc_pkg::DELAY_W-1:0];
			ihc_pkg::REG_ON_DELAY:  model_cfg.on_delay_ticks = data[ihc_pkg::DELAY_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_levels(input logic [ihc_pkg::LEVEL_W-1:0] knob_on,
			input logic [ihc_pkg::LEVEL_W-1:0] knob_off,
			input logic [ihc_pkg::LEVEL_W-1:0] day, input logic [ihc_pkg::LEVEL_W-1:0] dusk,
			input logic [ihc_pkg::LEVEL_W-1:0] off_delay,
			input logic [ihc_pkg::LEVEL_W-1:0] on_delay);
		write_reg(ihc_pkg::REG_KNOB_ON, knob_on);
		write_reg(ihc_pkg::REG_KNOB_OFF, knob_off);
		write_reg(ihc_pkg::REG_DAYLIGHT, day);
		write_reg(ihc_pkg::REG_DUSK, dusk);
		write_reg(ihc_pkg::REG_OFF_DELAY, off_delay);
		write_reg(ihc_pkg::REG_ON_DELAY, on_delay);
	endtask

	// Mostly runs of steady light of about the length of the delay in force, so that the
	// counter reaches its target, broken up by button sequences. While the engine is off
	// the sequences come often, because without the engine nothing else is exercised.
	task automatic random_stream(input int n);
		int sent;
		int run_len;
		int hold;
		int rel;
		int k;
		light_band_e band;
		logic seat;
		logic [ihc_pkg::LEVEL_W-1:0] knob;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < (engine_on ? 8 : 60)) begin
				seat = ($urandom_range(0, 4) != 0);
				hold = $urandom_range(1, 3);
				rel = $urandom_range(1, 2);
				for (k = 0; k < hold; k++)
					send_tick(make_tick(1'b1, seat, pick_knob(), pick_light(LIGHT_ANY)));
				for (k = 0; k < rel; k++)
					send_tick(make_tick(1'b0, seat, pick_knob(), pick_light(LIGHT_ANY)));
				sent += hold + rel;
			end else begin
				band = light_band_e'($urandom_range(0, 3));
				knob = pick_knob();
				run_len = $urandom_range(1, ((band == LIGHT_DAY) ? model_cfg.off_delay_ticks
				                                                  : model_cfg.on_delay_ticks) + 3);
				for (k = 0; k < run_len; k++) begin
					send_tick(make_tick($urandom_range(0, 39) == 0, 1'($urandom_range(0, 1)),
						($urandom_range(0, 3) == 0) ? pick_knob() : knob, pick_light(band)));
				end
				sent += run_len;
			end
		end
	endtask

	// Reset defaults: an empty seat must not start the engine, a held button fires only
	// after its release, and the knob thresholds force the lamps either way.
	task automatic test_start_and_knob();
		press_and_release(1'b0, 12'd4095, 12'd0);
		send_tick(make_tick(1'b1, 1'b1, 12'd4095, 12'd0));
		send_tick(make_tick(1'b1, 1'b1, 12'd4095, 12'd0));
		send_tick(make_tick(1'b0, 1'b1, 12'd4095, 12'd0));
		send_tick(make_tick(1'b0, 1'b1, 12'd4095, 12'd0));
		send_tick(make_tick(1'b0, 1'b1, 12'd0, 12'd0));
		send_tick(make_tick(1'b0, 1'b1, ihc_pkg::RST_KNOB_ON, 12'd0));
		send_tick(make_tick(1'b0, 1'b1, ihc_pkg::RST_KNOB_OFF, 12'd0));
	endtask

	// Auto mode with a zero on delay, so that dusk switches the lamps at once, and a
	// short off delay. Mid light must clear the counter and a forced knob must hold it.
	task automatic test_auto_switching();
		wait_idle();
		write_reg(ihc_pkg::REG_OFF_DELAY, 12'd2);
		write_reg(ihc_pkg::REG_ON_DELAY, 12'd0);
		send_tick(make_tick(1'b0, 1'b1, 12'd2000, 12'd0));
		send_tick(make_tick(1'b0, 1'b1, 12'd2000, 12'd4095));
		send_tick(make_tick(1'b0, 1'b1, 12'd2000, ihc_pkg::RST_DAYLIGHT));
		send_tick(make_tick(1'b0, 1'b1, 12'd2000, ihc_pkg::RST_DUSK));
		send_tick(make_tick(1'b0, 1'b1, 12'd2000, 12'd4095));
		send_tick(make_tick(1'b0, 1'b1, 12'd2000, 12'd3000));
		send_tick(make_tick(1'b0, 1'b1, 12'd2000, 12'd4095));
		send_tick(make_tick(1'b0, 1'b1, 12'd4095, 12'd4095));
		send_tick(make_tick(1'b0, 1'b1, 12'd2000, 12'd4095));
	endtask

	// Overlapping thresholds: the knob-on test wins over knob-off, and the daylight test
	// wins over dusk. A firing with the seat taken must still stop a running engine.
	task automatic test_level_overlap();
		wait_idle();
		set_levels(12'd1000, 12'd3000, 12'd1000, 12'd3000, 12'd1, 12'd2);
		press_and_release(1'b1, 12'd2000, 12'd2000);
		press_and_release(1'b1, 12'd2000, 12'd2000);
		send_tick(make_tick(1'b0, 1'b1, 12'd999, 12'd2000));
		wait_idle();
		write_reg(ihc_pkg::REG_KNOB_ON, 12'd4095);
		write_reg(ihc_pkg::REG_KNOB_OFF, 12'd0);
		send_tick(make_tick(1'b0, 1'b1, 12'd2000, 12'd500));
		send_tick(make_tick(1'b0, 1'b1, 12'd2000, 12'd500));
		send_tick(make_tick(1'b0, 1'b1, 12'd2000, 12'd2000));
	endtask

	// The receiver holds off for a long stretch while ticks keep coming back to back, so
	// the two beat registers fill and tick_ready has to drop.
	task automatic test_backpressure();
		int k;
		wait_idle();
		pacing_on = 1'b0;
		hold_asks++;
		for (k = 0; k < 40; k++) begin
			send_tick(make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				pick_knob(), pick_light(LIGHT_ANY)));
		end
		pacing_on = 1'b1;
		wait_idle();
	endtask

	// Long delays, written with the upper data bits set, and an unbroken run of dusk
	// ticks long enough for the counter to climb through its upper bit to the on delay.
	task automatic test_counter_ceiling();
		int k;
		wait_idle();
		set_levels(12'hFFF, 12'h000, 12'hFFF, 12'hFFE, 12'hFFF, 12'hE00);
		while (!engine_on || btn_phase != ihc_pkg::PH_WAIT_PRESS)
			press_and_release(1'b1, 12'd2048, 12'd100);
		for (k = 0; k < CEILING_ITEMS; k++) begin
			send_tick(make_tick(1'b0, 1'($urandom_range(0, 1)), 12'($urandom_range(1, 4094)),
				12'($urandom_range(0, 4094))));
		end
	endtask

	// Several register settings in turn, from the defaults to both extremes of the scale,
	// each followed by a stretch of random ticks.
	task automatic test_random_settings();
		int p;
		for (p = 0; p < 7; p++) begin
			wait_idle();
			case (p)
				0: set_levels(ihc_pkg::RST_KNOB_ON, ihc_pkg::RST_KNOB_OFF,
					ihc_pkg::RST_DAYLIGHT, ihc_pkg::RST_DUSK,
					12'(ihc_pkg::RST_OFF_DELAY), 12'(ihc_pkg::RST_ON_DELAY));
				1: set_levels(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
					12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
					12'($urandom_range(0, 6)), 12'($urandom_range(0, 6)));
				2: set_levels(12'h000, 12'h000, 12'h000, 12'h000,
					12'($urandom_range(0, 6)), 12'($urandom_range(0, 6)));
				3: set_levels(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
					12'($urandom_range(0, 6)), 12'($urandom_range(0, 6)));
				4: set_levels(12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'd1, 12'd1);
				5: begin
					set_levels(12'($urandom_range(2500, 4095)), 12'($urandom_range(0, 1500)),
						12'($urandom_range(0, 1800)), 12'($urandom_range(2200, 4095)),
						12'd0, 12'd0);
					write_reg(REG_SPARE_LO, 12'($urandom_range(0, 4095)));
					write_reg(REG_SPARE_HI, 12'($urandom_range(0, 4095)));
				end
				default: set_levels(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
					12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
					{2'($urandom_range(0, 3)), 10'($urandom_range(0, 20))},
					{2'($urandom_range(0, 3)), 10'($urandom_range(0, 20))});
			endcase
			random_stream(PHASE_ITEMS);
		end
	endtask

	// Receiver: a pattern of ready whose character is redrawn at random when its mode runs out,
	// and on request a long hold-off counted here.
	int hold_seen = 0;
	int hold_left = 0;
	int mode_left = 0;
	int rx_count = 0;
	rx_mode_e rx_mode = RX_OPEN;

	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			rx_count++;
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_e'($urandom_range(0, 3));
					mode_left = $urandom_range(8, 80);
				end
				mode_left--;
				case (rx_mode)
					RX_OPEN:     result_ready <= 1'b1;
					RX_HALF:     result_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE:   result_ready <= ($urandom_range(0, 3) == 0);
					default:     result_ready <= ((rx_count % 4) != 3);
				endcase
			end
		end
	end

	// Every result beat is compared with the oldest outstanding prediction.
	always @(posedge clk) begin
		ihc_pkg::result_beat_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no tick outstanding: engine_running %0b lamps_lit %0b",
					result.engine_running, result.lamps_lit);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (result.engine_running !== want.engine_running) begin
					$error("engine_running: expected %0b, got %0b",
						want.engine_running, result.engine_running);
					mismatches++;
				end
				if (result.lamps_lit !== want.lamps_lit) begin
					$error("lamps_lit: expected %0b, got %0b", want.lamps_lit, result.lamps_lit);
					mismatches++;
				end
			end
		end
	end

	// A long run of cycles without a single beat on either channel means the block hung.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((tick_valid && tick_ready) || (result_valid && result_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	initial begin
		reset_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_start_and_knob();
		test_auto_switching();
		test_level_overlap();
		test_backpressure();
		test_counter_ceiling();
		test_random_settings();
		wait_idle();
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/ihc_pkg.sv
rtl/ihc_cfg_regs.sv
rtl/ihc_step.sv
rtl/ignition_and_auto_headlamp_controller_core.sv
rtl/ihc_checker.sv
tb/tb.sv
